FILE: rtl/keyed_round_wire_sequencer_unit_assert.svh
`ifndef KEYED_ROUND_WIRE_SEQUENCER_UNIT_ASSERT_SVH
`define KEYED_ROUND_WIRE_SEQUENCER_UNIT_ASSERT_SVH

// Checks that cons holds in the same cycle as ante, sampled on clk_i.
`define KRWS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("krws same-cycle check failed");

// Checks that cons holds in the cycle after ante.
`define KRWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("krws next-cycle check failed");

`endif

FILE: rtl/krws_pkg.sv
package krws_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned BitsW  = 40;
  localparam int unsigned CountW = 6;

  localparam logic [ValueW-1:0] RoundPoly = 32'h8050_0062;

  // Fixed command bytes of the preamble.
  localparam logic [7:0] CmdFirst  = 8'h34;
  localparam logic [7:0] CmdSecond = 8'h7C;
  localparam logic [7:0] CmdThird  = 8'h4E;

  // Wire-form masks.
  localparam logic [7:0] CmdClrMask  = 8'hFE;
  localparam logic [7:0] CmdSetMask  = 8'h81;
  localparam logic [7:0] WireHigh    = 8'h80;
  localparam logic [7:0] PulseIdle   = 8'h84;
  localparam logic [7:0] PulseBit    = 8'h20;
  localparam logic [7:0] QueryStrobe = 8'h10;

  // Position of a write within its three-write group.
  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseStrobe = 2'd1;
  localparam logic [1:0] PhaseLast   = 2'd2;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_ANSWER = 1'b1
  } op_e;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_RESULT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    JOB_START  = 2'd0,
    JOB_QUERY  = 2'd1,
    JOB_FINISH = 2'd2
  } job_e;

  // One job handed from the front to the back.
  typedef struct packed {
    job_e              job;
    logic [7:0]        query;
    logic [ValueW-1:0] final_value;
    logic [BitsW-1:0]  answer_bits;
  } job_t;

  function automatic logic [7:0] cmd_pick(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CmdFirst;
      2'd1:    b = CmdSecond;
      default: b = CmdThird;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cmd_wire(input logic [7:0] b, input logic strobe);
    return strobe ? (b | CmdSetMask) : ((b & CmdClrMask) | WireHigh);
  endfunction

  function automatic logic [7:0] pulse_wire(input logic strobe);
    return strobe ? (PulseIdle | PulseBit) : PulseIdle;
  endfunction

  function automatic logic [7:0] query_wire(input logic [7:0] q, input logic strobe);
    logic [7:0] p;
    p = {1'b1, q[4:3], 1'b0, q[2:0], 1'b0};
    return strobe ? (p | QueryStrobe) : p;
  endfunction

endpackage

FILE: rtl/krws_if.sv
// Input channel: start items and answer bits.
interface krws_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] start_value;
  logic        answer_bit;

  modport source (output valid, output op, output start_value, output answer_bit,
                  input ready);
  modport sink (input valid, input op, input start_value, input answer_bit,
                output ready);
endinterface

// Output channel: port writes and round results.
interface krws_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  port_byte;
  logic [31:0] final_value;
  logic [39:0] answer_bits;
  logic        last;

  modport source (output valid, output kind, output port_byte, output final_value,
                  output answer_bits, output last, input ready);
  modport sink (input valid, input kind, input port_byte, input final_value,
                input answer_bits, input last, output ready);
endinterface

FILE: rtl/krws_front.sv
module krws_front #(
  parameter int unsigned ShiftSteps = 39
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        op_i,
  input  logic [krws_pkg::ValueW-1:0] start_value_i,
  input  logic                        answer_bit_i,
  input  logic                        space_i,
  output logic                        ready_o,
  output logic                        push_o,
  output krws_pkg::job_t              job_o,
  output logic                        busy_o
);

  logic                        busy_q, busy_d;
  logic [krws_pkg::ValueW-1:0] round_q, round_d;
  logic [krws_pkg::CountW-1:0] count_q, count_d;
  logic [krws_pkg::BitsW-1:0]  store_q, store_d;

  logic                        accept;
  logic                        old_low;
  logic [1:0]                  sel;
  logic [krws_pkg::ValueW-1:0] shifted;
  logic [krws_pkg::BitsW-1:0]  store_new;
  logic                        finish;

  assign ready_o = space_i;
  assign accept  = valid_i & space_i;
  assign busy_o  = busy_q;

  // One shift step of the round register and the recorded answer.
  always_comb begin
    old_low = round_q[0];
    sel     = {old_low, answer_bit_i};
    shifted = (round_q >> 1) ^ ((answer_bit_i ^ old_low) ? krws_pkg::RoundPoly : '0);
    if (count_q < krws_pkg::CountW'(krws_pkg::BitsW)) begin
      store_new = store_q | ({{(krws_pkg::BitsW-1){1'b0}}, answer_bit_i}
                  << (krws_pkg::CountW'(krws_pkg::BitsW - 1) - count_q));
    end else begin
      store_new = store_q;
    end
    finish = count_q >= krws_pkg::CountW'(ShiftSteps);
  end

  // Classify the item, update the round state and build the job.
  always_comb begin
    busy_d            = busy_q;
    round_d           = round_q;
    count_d           = count_q;
    store_d           = store_q;
    push_o            = 1'b0;
    job_o.job         = krws_pkg::JOB_QUERY;
    job_o.query       = shifted[{sel, 3'b000} +: 8];
    job_o.final_value = '0;
    job_o.answer_bits = '0;
    if (accept) begin
      if (op_i == krws_pkg::OP_START) begin
        busy_d      = 1'b1;
        round_d     = start_value_i;
        count_d     = '0;
        store_d     = '0;
        push_o      = 1'b1;
        job_o.job   = krws_pkg::JOB_START;
        job_o.query = start_value_i[7:0];
      end else if (busy_q) begin
        store_d = store_new;
        count_d = count_q + krws_pkg::CountW'(1);
        push_o  = 1'b1;
        if (finish) begin
          busy_d            = 1'b0;
          job_o.job         = krws_pkg::JOB_FINISH;
          job_o.final_value = round_q;
          job_o.answer_bits = store_new;
        end else begin
          round_d = shifted;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= '0;
      count_q <= '0;
      store_q <= '0;
    end else begin
      busy_q  <= busy_d;
      round_q <= round_d;
      count_q <= count_d;
      store_q <= store_d;
    end
  end

endmodule

FILE: rtl/krws_fifo.sv
module krws_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  krws_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output krws_pkg::job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  krws_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/krws_back.sv
module krws_back #(
  parameter int unsigned SkPulses = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  krws_pkg::job_t              job_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic                        kind_o,
  output logic [7:0]                  port_byte_o,
  output logic [krws_pkg::ValueW-1:0] final_value_o,
  output logic [krws_pkg::BitsW-1:0]  answer_bits_o,
  output logic                        last_o
);

  // Groups: three commands, the pulses, the closing command, the query.
  localparam int unsigned GrpW = $clog2(SkPulses + 5);
  localparam logic [GrpW-1:0] PulseGrp = GrpW'(3);
  localparam logic [GrpW-1:0] CloseGrp = GrpW'(3 + SkPulses);
  localparam logic [GrpW-1:0] QueryGrp = GrpW'(4 + SkPulses);

  logic            started_q, started_d;
  logic [GrpW-1:0] grp_q, grp_d;
  logic [1:0]      phase_q, phase_d;
  logic            out_valid_q;

  logic                        load;
  logic [GrpW-1:0]             cur_grp;
  logic [1:0]                  cur_phase;
  logic                        strobe;
  logic                        beat_last;
  logic                        beat_kind;
  logic [7:0]                  beat_byte;
  logic [krws_pkg::ValueW-1:0] beat_value;
  logic [krws_pkg::BitsW-1:0]  beat_bits;

  logic                        kind_q;
  logic [7:0]                  byte_q;
  logic [krws_pkg::ValueW-1:0] value_q;
  logic [krws_pkg::BitsW-1:0]  bits_q;
  logic                        last_q;

  assign load  = !out_valid_q || ready_i;
  assign pop_o = load && !empty_i && beat_last;

  // Work out the beat for the job at the head of the queue.
  always_comb begin
    cur_grp    = started_q ? grp_q
               : ((job_i.job == krws_pkg::JOB_QUERY) ? QueryGrp : '0);
    cur_phase  = started_q ? phase_q : krws_pkg::PhaseFirst;
    strobe     = cur_phase == krws_pkg::PhaseStrobe;
    beat_kind  = krws_pkg::KIND_WRITE;
    beat_value = '0;
    beat_bits  = '0;
    beat_last  = (cur_grp == QueryGrp) && (cur_phase == krws_pkg::PhaseLast);
    if (cur_grp < PulseGrp) begin
      beat_byte = krws_pkg::cmd_wire(krws_pkg::cmd_pick(cur_grp[1:0]), strobe);
    end else if (cur_grp < CloseGrp) begin
      beat_byte = krws_pkg::pulse_wire(strobe);
    end else if (cur_grp == CloseGrp) begin
      beat_byte = krws_pkg::cmd_wire(krws_pkg::CmdThird, strobe);
    end else begin
      beat_byte = krws_pkg::query_wire(job_i.query, strobe);
    end
    if (job_i.job == krws_pkg::JOB_FINISH) begin
      beat_kind  = krws_pkg::KIND_RESULT;
      beat_byte  = '0;
      beat_value = job_i.final_value;
      beat_bits  = job_i.answer_bits;
      beat_last  = 1'b1;
    end
  end

  // Step through groups and phases.
  always_comb begin
    started_d = started_q;
    grp_d     = grp_q;
    phase_d   = phase_q;
    if (load && !empty_i) begin
      if (beat_last) begin
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        if (cur_phase == krws_pkg::PhaseLast) begin
          grp_d   = cur_grp + GrpW'(1);
          phase_d = krws_pkg::PhaseFirst;
        end else begin
          grp_d   = cur_grp;
          phase_d = cur_phase + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      grp_q       <= '0;
      phase_q     <= krws_pkg::PhaseFirst;
      out_valid_q <= 1'b0;
    end else begin
      started_q <= started_d;
      grp_q     <= grp_d;
      phase_q   <= phase_d;
      if (load) begin
        out_valid_q <= !empty_i;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      kind_q  <= beat_kind;
      byte_q  <= beat_byte;
      value_q <= beat_value;
      bits_q  <= beat_bits;
      last_q  <= beat_last;
    end
  end

  assign valid_o       = out_valid_q;
  assign kind_o        = kind_q;
  assign port_byte_o   = byte_q;
  assign final_value_o = value_q;
  assign answer_bits_o = bits_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/keyed_round_wire_sequencer_unit.sv
// The job for an input transfer passes through the job queue into the output register.
// Throughput: one result per cycle if out_o.ready is high, set by the output register;
// a start yields 15 + 3*SK_PULSES writes (63), an answer 3 writes, 1 result or none.
// Inputs are taken every cycle while the two-entry job queue has room.
// Reset (rst_ni low, asynchronous) clears the round state, the queue and the output
// valid; there is no clearing pass.
`include "keyed_round_wire_sequencer_unit_assert.svh"

module keyed_round_wire_sequencer_unit #(
  parameter int unsigned SHIFT_STEPS = 39,
  parameter int unsigned SK_PULSES   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  krws_in_if.sink    in_i,
  krws_out_if.source out_o
);

  logic           fifo_full;
  logic           fifo_empty;
  logic           front_push;
  logic           front_busy;
  logic           back_pop;
  krws_pkg::job_t front_job;
  krws_pkg::job_t head_job;

  // Front: accept and classify items, keep the round state.
  krws_front #(
    .ShiftSteps(SHIFT_STEPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .op_i         (in_i.op),
    .start_value_i(in_i.start_value),
    .answer_bit_i (in_i.answer_bit),
    .space_i      (!fifo_full),
    .ready_o      (in_i.ready),
    .push_o       (front_push),
    .job_o        (front_job),
    .busy_o       (front_busy)
  );

  // Job queue between front and back.
  krws_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_job),
    .full_o (fifo_full),
    .pop_i  (back_pop),
    .empty_o(fifo_empty),
    .data_o (head_job)
  );

  // Back: expand jobs into port writes and results.
  krws_back #(
    .SkPulses(SK_PULSES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (fifo_empty),
    .job_i        (head_job),
    .pop_o        (back_pop),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .kind_o       (out_o.kind),
    .port_byte_o  (out_o.port_byte),
    .final_value_o(out_o.final_value),
    .answer_bits_o(out_o.answer_bits),
    .last_o       (out_o.last)
  );

  // A finished round is a single result, so it closes its item and drives no byte.
  `KRWS_ASSERT_SAME(a_result_last, out_o.valid && (out_o.kind == krws_pkg::KIND_RESULT), out_o.last && (out_o.port_byte == 8'h00))
  // Sending the finish job ends the round.
  `KRWS_ASSERT_NEXT(a_finish_idle, front_push && (front_job.job == krws_pkg::JOB_FINISH), !front_busy)
  // The back only retires a job that is in the queue.
  `KRWS_ASSERT_SAME(a_pop_nonempty, back_pop, !fifo_empty)

endmodule

FILE: verif/keyed_round_wire_sequencer_unit_tb.sv
module keyed_round_wire_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ShiftSteps  = 39;
  localparam int unsigned SkPulses    = 16;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned CycleLimit  = 5_000_000;
  localparam int unsigned DrainCycles = 16;

  // One expected transfer on the output channel.
  typedef struct {
    krws_pkg::kind_e kind;
    logic [7:0]      port_byte;
    logic [31:0]     final_value;
    logic [39:0]     answer_bits;
    logic            last;
  } wire_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic sink_ready = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned counted_items = 0;
  bit quiet = 1'b0;

  // Shadow copy of the round state.
  logic        round_busy = 1'b0;
  logic [31:0] round_value = '0;
  logic [5:0]  answer_count = '0;
  logic [39:0] answer_store = '0;

  wire_item_t expected_wire_q[$];

  krws_in_if in_if ();
  krws_out_if out_if ();

  assign out_if.ready = sink_ready;

  keyed_round_wire_sequencer_unit #(
    .SHIFT_STEPS(ShiftSteps),
    .SK_PULSES  (SkPulses)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #4ns;
    clk_i = 1'b1;
    #4ns;
  end

  // Expected-result builders.
  function automatic void push_write(input logic [7:0] byte_val, input logic last_flag);
    wire_item_t w;
    w.kind        = krws_pkg::KIND_WRITE;
    w.port_byte   = byte_val;
    w.final_value = '0;
    w.answer_bits = '0;
    w.last        = last_flag;
    expected_wire_q.push_back(w);
  endfunction

  function automatic void push_command(input logic [7:0] cmd);
    push_write((cmd & 8'hFE) | 8'h80, 1'b0);
    push_write(cmd | 8'h81, 1'b0);
    push_write((cmd & 8'hFE) | 8'h80, 1'b0);
  endfunction

  // A query spreads the low five bits of q over data lines 1-3 and 5-6.
  function automatic void push_query(input logic [7:0] q, input logic last_flag);
    logic [7:0] p;
    p = ((q << 1) & 8'h0E) | ((q << 2) & 8'h60) | 8'h80;
    push_write(p, 1'b0);
    push_write(p | 8'h10, 1'b0);
    push_write(p, last_flag);
  endfunction

  // Advances the shadow round by one accepted input transfer.
  function automatic void advance_round(input krws_pkg::op_e op,
                                        input logic [31:0] value,
                                        input logic abit);
    logic [1:0] sel;
    wire_item_t r;
    if (op == krws_pkg::OP_START) begin
      round_value  = value;
      answer_count = '0;
      answer_store = '0;
      round_busy   = 1'b1;
      counted_items++;
      push_command(krws_pkg::CmdFirst);
      push_command(krws_pkg::CmdSecond);
      push_command(krws_pkg::CmdThird);
      for (int i = 0; i < SkPulses; i++) begin
        push_write(8'h84, 1'b0);
        push_write(8'hA4, 1'b0);
        push_write(8'h84, 1'b0);
      end
      push_command(krws_pkg::CmdThird);
      push_query(round_value[7:0], 1'b1);
    end else if (round_busy) begin
      counted_items++;
      if (answer_count < 40) answer_store[39 - answer_count] = abit;
      if (answer_count >= ShiftSteps) begin
        r.kind        = krws_pkg::KIND_RESULT;
        r.port_byte   = '0;
        r.final_value = round_value;
        r.answer_bits = answer_store;
        r.last        = 1'b1;
        expected_wire_q.push_back(r);
        round_busy = 1'b0;
      end else begin
        sel = {round_value[0], abit};
        if (abit != round_value[0]) begin
          round_value = (round_value >> 1) ^ krws_pkg::RoundPoly;
        end else begin
          round_value = round_value >> 1;
        end
        push_query(8'(round_value >> (8 * sel)), 1'b1);
      end
      answer_count = answer_count + 6'd1;
    end
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Drives one item and waits for its transfer; expects to be called at a rising edge.
  task automatic send_item(input krws_pkg::op_e op, input logic [31:0] value,
                           input logic abit);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.start_value <= value;
    in_if.answer_bit  <= abit;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    advance_round(op, value, abit);
  endtask

  // Sends n answers, taking the bits of pattern from the top down.
  task automatic send_answers(input logic [15:0] pattern, input int n);
    for (int i = 0; i < n; i++) begin
      send_item(krws_pkg::OP_ANSWER, $urandom(), pattern[15 - i]);
    end
  endtask

  task automatic test_idle_answers();
    send_item(krws_pkg::OP_ANSWER, 32'h0000_0000, 1'b0);
    send_item(krws_pkg::OP_ANSWER, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Seeds at the extremes and a mixed pattern, with each start after the first landing in the middle of a round.
  task automatic test_restart_extremes();
    send_item(krws_pkg::OP_START, 32'h0000_0000, 1'b0);
    send_answers(16'b1001_0000_0000_0000, 4);
    send_item(krws_pkg::OP_START, 32'hFFFF_FFFF, 1'b1);
    send_answers(16'b1101_0000_0000_0000, 6);
    send_item(krws_pkg::OP_START, 32'h8000_0001, 1'b0);
    send_answers(16'b0110_0000_0000_0000, 4);
    send_item(krws_pkg::OP_START, 32'h5A5A_A5A5, 1'b1);
    send_answers(16'b1000_0000_0000_0000, 2);
  endtask

  // Mostly complete rounds with random seeds and answer patterns, plus cut-short
  // rounds and stray answers once a round has finished.
  task automatic test_random_rounds();
    int unsigned base;
    int unsigned n_answers;
    int unsigned mode;
    logic [31:0] seed_val;
    logic abit;
    base = counted_items;
    while (counted_items - base < RandomItems) begin
      quiet = ($urandom_range(3) == 0);
      case ($urandom_range(7))
        0:       seed_val = 32'h0000_0000;
        1:       seed_val = 32'hFFFF_FFFF;
        default: seed_val = $urandom();
      endcase
      mode = $urandom_range(5);
      n_answers = ($urandom_range(4) == 0) ? $urandom_range(39, 1) : 40;
      send_item(krws_pkg::OP_START, seed_val, 1'($urandom_range(1)));
      for (int i = 0; i < n_answers; i++) begin
        case (mode)
          0:       abit = 1'b0;
          1:       abit = 1'b1;
          2:       abit = 1'(i);
          default: abit = 1'($urandom_range(1));
        endcase
        send_item(krws_pkg::OP_ANSWER, $urandom(), abit);
      end
      if (n_answers == 40 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(2, 1)) begin
          send_item(krws_pkg::OP_ANSWER, $urandom(), 1'($urandom_range(1)));
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Output backpressure: random stalls, short ones mostly.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
      if (!quiet && $urandom_range(99) < 20) begin
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                               : $urandom_range(3, 1);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Compares each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    wire_item_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_wire_q.size() == 0) begin
        $error("unexpected output transfer: kind %0h byte %0h",
               out_if.kind, out_if.port_byte);
        mismatches++;
      end else begin
        w = expected_wire_q.pop_front();
        check_field("kind", 64'(w.kind), 64'(out_if.kind));
        check_field("port_byte", 64'(w.port_byte), 64'(out_if.port_byte));
        check_field("final_value", 64'(w.final_value), 64'(out_if.final_value));
        check_field("answer_bits", 64'(w.answer_bits), 64'(out_if.answer_bits));
        check_field("last", 64'(w.last), 64'(out_if.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("keyed_round_wire_sequencer_unit regression: fail");
      $finish;
    end
  end

  initial begin
    in_if.valid       <= 1'b0;
    in_if.op          <= krws_pkg::OP_START;
    in_if.start_value <= '0;
    in_if.answer_bit  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_answers();
    test_restart_extremes();
    test_random_rounds();
    in_if.valid <= 1'b0;

    // Let the remaining writes drain, then watch for strays.
    while (expected_wire_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("keyed_round_wire_sequencer_unit regression: pass");
    end else begin
      $display("keyed_round_wire_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: keyed_round_wire_sequencer_unit.f
+incdir+rtl
rtl/krws_pkg.sv
rtl/krws_if.sv
rtl/krws_front.sv
rtl/krws_fifo.sv
rtl/krws_back.sv
rtl/keyed_round_wire_sequencer_unit.sv
verif/keyed_round_wire_sequencer_unit_tb.sv
